FILE: rtl/core/sntp_client_poll_timekeeper_top_assert.svh
// ---------------------------------------------------------------------------
// SNTP poll timekeeper assertion macros
// Shorthand for the clocked, reset-gated checks of the top level.
// ---------------------------------------------------------------------------
`ifndef SNTP_CLIENT_POLL_TIMEKEEPER_TOP_ASSERT_SVH
`define SNTP_CLIENT_POLL_TIMEKEEPER_TOP_ASSERT_SVH

// same-cycle implication
`define SNTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SNTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sntp_pkg.sv
// ---------------------------------------------------------------------------
// SNTP poll timekeeper package
// Constants, register indexes and helpers of the SNTP poll timekeeper.
// ---------------------------------------------------------------------------
package sntp_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SERVER_PORT      = 2'd0,
        CFG_RETRY_INTERVAL   = 2'd1,
        CFG_REFRESH_INTERVAL = 2'd2,
        CFG_EXPIRY_INTERVAL  = 2'd3
    } t_cfg_index;

    localparam logic [15:0] ServerPortRst     = 16'd123;
    localparam logic [31:0] RetryIntervalRst  = 32'd5000;
    localparam logic [31:0] RefreshIntervalRst = 32'd300000;
    localparam logic [31:0] ExpiryIntervalRst = 32'd1209600000;

    localparam logic [31:0] NtpUnixDelta  = 32'd2208988800;
    localparam logic [15:0] MinReplyBytes = 16'd48;

    // fraction / 4294968 = (fraction >> 3) / 536871, exact reciprocal for 29 bits
    localparam logic [63:0] FracDivisor    = 64'd536871;
    localparam int unsigned FracShift      = 49;
    localparam logic [63:0] FracRecipWide  =
        ((64'd1 << FracShift) + FracDivisor - 64'd1) / FracDivisor;
    localparam logic [29:0] FracRecip      = FracRecipWide[29:0];

    // ms / 1000 = (ms >> 3) / 125, exact reciprocal for 29 bits
    localparam logic [63:0] SecDivisor     = 64'd125;
    localparam int unsigned SecShift       = 36;
    localparam logic [63:0] SecRecipWide   =
        ((64'd1 << SecShift) + SecDivisor - 64'd1) / SecDivisor;
    localparam logic [29:0] SecRecip       = SecRecipWide[29:0];

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

FILE: rtl/core/sntp_client_poll_timekeeper_top.sv
// ---------------------------------------------------------------------------
// SNTP poll timekeeper
// Tracks Unix time from SNTP replies and schedules time requests per poll.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  poll      in         i_in_valid / o_in_stall       now, force, reply fields
//  result    out        o_out_valid / i_out_stall     send, accepted, known, unix
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
//  One poll word is taken per cycle unless the pipeline is stalled; each result
//  passes input register, state update, fraction divide, seconds divide, output.
//  The state update stage is the only loop.
//  Synchronous active-low reset clears valids and state and loads config defaults.
//  A stalled output backs up stage by stage; empty stages keep taking words.
// ---------------------------------------------------------------------------
`include "sntp_client_poll_timekeeper_top_assert.svh"

module sntp_client_poll_timekeeper_top
    import sntp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // poll channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_now_ms,
    input  logic        i_force_query,
    input  logic        i_reply_present,
    input  logic [15:0] i_reply_port,
    input  logic [15:0] i_reply_length,
    input  logic [31:0] i_tx_seconds_raw,
    input  logic [31:0] i_tx_fraction_raw,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_request,
    output logic        o_reply_accepted,
    output logic        o_time_known,
    output logic [31:0] o_unix_seconds,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // configuration
    logic [15:0] r_server_port;
    logic [31:0] r_retry_ms;
    logic [31:0] r_refresh_ms;
    logic [31:0] r_expiry_ms;

    // timekeeping state
    logic [31:0] r_last_req_ms;
    logic [31:0] r_capture_ms;
    logic [31:0] r_base_sec;
    logic [31:0] r_frac_raw;

    // stage 0: input register
    logic        r0_v;
    logic [31:0] r0_now;
    logic        r0_force;
    logic        r0_present;
    logic [15:0] r0_port;
    logic [15:0] r0_len;
    logic [31:0] r0_tx_s;
    logic [31:0] r0_tx_f;

    // stage 1: after state update
    logic        r1_v;
    logic        r1_send;
    logic        r1_acc;
    logic [31:0] r1_base;
    logic [31:0] r1_diff;
    logic [31:0] r1_frac_raw;

    // stage 2: fraction in ms
    logic        r2_v;
    logic        r2_send;
    logic        r2_acc;
    logic [31:0] r2_base;
    logic [31:0] r2_diff;
    logic [9:0]  r2_frac_ms;

    // stage 3: elapsed seconds
    logic        r3_v;
    logic        r3_send;
    logic        r3_acc;
    logic [31:0] r3_base;
    logic [22:0] r3_sec;

    // output register
    logic        r_out_valid;
    logic        r_out_send;
    logic        r_out_acc;
    logic        r_out_known;
    logic [31:0] r_out_unix;

    logic en0, en1, en2, en3, en_out;

    // state update signals
    logic [31:0] n_last_req_ms;
    logic [31:0] n_capture_ms;
    logic [31:0] n_base_sec;
    logic [31:0] n_frac_raw;
    logic        n_send;
    logic        n_acc;
    logic [31:0] last_eff;
    logic [31:0] delta;
    logic [31:0] base_kept;

    logic [58:0] frac_prod;
    logic [31:0] elapsed;
    logic [58:0] sec_prod;

    // ------------------------------------------------------------------
    // stage enables: a stage moves when it is empty or its successor moves
    // ------------------------------------------------------------------
    assign en_out     = !r_out_valid || !i_out_stall;
    assign en3        = !r3_v || en_out;
    assign en2        = !r2_v || en3;
    assign en1        = !r1_v || en2;
    assign en0        = !r0_v || en1;
    assign o_in_stall = !en0;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_port <= ServerPortRst;
            r_retry_ms    <= RetryIntervalRst;
            r_refresh_ms  <= RefreshIntervalRst;
            r_expiry_ms   <= ExpiryIntervalRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SERVER_PORT:      r_server_port <= i_cfg_data[15:0];
                CFG_RETRY_INTERVAL:   r_retry_ms    <= i_cfg_data;
                CFG_REFRESH_INTERVAL: r_refresh_ms  <= i_cfg_data;
                CFG_EXPIRY_INTERVAL:  r_expiry_ms   <= i_cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 0
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en0) begin
            r0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_now     <= i_now_ms;
            r0_force   <= i_force_query;
            r0_present <= i_reply_present;
            r0_port    <= i_reply_port;
            r0_len     <= i_reply_length;
            r0_tx_s    <= i_tx_seconds_raw;
            r0_tx_f    <= i_tx_fraction_raw;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: force backdate, reply check, expiry and scheduling
    // ------------------------------------------------------------------
    always_comb begin
        last_eff  = r0_force ? (r0_now - r_refresh_ms) : r_last_req_ms;
        delta     = r0_now - last_eff;
        base_kept = (delta >= r_expiry_ms) ? 32'd0 : r_base_sec;
        n_acc     = r0_present && (r0_port == r_server_port) && (r0_len >= MinReplyBytes);

        n_capture_ms  = r_capture_ms;
        n_base_sec    = r_base_sec;
        n_frac_raw    = r_frac_raw;
        n_last_req_ms = last_eff;
        n_send        = 1'b0;

        if (n_acc) begin
            n_capture_ms = r0_now;
            n_base_sec   = swap_bytes(r0_tx_s) - NtpUnixDelta;
            n_frac_raw   = swap_bytes(r0_tx_f);
        end else begin
            n_base_sec = base_kept;
            n_send     = (delta >= r_refresh_ms) ||
                         ((base_kept == 32'd0) && (delta > r_retry_ms));
            if (n_send) begin
                n_last_req_ms = r0_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_req_ms <= '0;
            r_capture_ms  <= '0;
            r_base_sec    <= '0;
            r_frac_raw    <= '0;
            r1_v          <= 1'b0;
        end else if (en1) begin
            r1_v <= r0_v;
            if (r0_v) begin
                r_last_req_ms <= n_last_req_ms;
                r_capture_ms  <= n_capture_ms;
                r_base_sec    <= n_base_sec;
                r_frac_raw    <= n_frac_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_send     <= n_send;
            r1_acc      <= n_acc;
            r1_base     <= n_base_sec;
            r1_diff     <= r0_now - n_capture_ms;
            r1_frac_raw <= n_frac_raw;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: fraction word to milliseconds
    // ------------------------------------------------------------------
    assign frac_prod = 59'(r1_frac_raw[31:3]) * 59'(FracRecip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_send    <= r1_send;
            r2_acc     <= r1_acc;
            r2_base    <= r1_base;
            r2_diff    <= r1_diff;
            r2_frac_ms <= frac_prod[FracShift +: 10];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: elapsed milliseconds to seconds
    // ------------------------------------------------------------------
    assign elapsed  = r2_diff + 32'(r2_frac_ms);
    assign sec_prod = 59'(elapsed[31:3]) * 59'(SecRecip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_send <= r2_send;
            r3_acc  <= r2_acc;
            r3_base <= r2_base;
            r3_sec  <= sec_prod[SecShift +: 23];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_send  <= r3_send;
            r_out_acc   <= r3_acc;
            r_out_known <= (r3_base != 32'd0);
            r_out_unix  <= (r3_base != 32'd0) ? (r3_base + 32'(r3_sec)) : 32'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_send_request   = r_out_send;
    assign o_reply_accepted = r_out_acc;
    assign o_time_known     = r_out_known;
    assign o_unix_seconds   = r_out_unix;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SNTP_ASSERT_NOW(a_acc_no_send, o_out_valid && o_reply_accepted, !o_send_request,
        "request raised on a poll whose reply was accepted")
    `SNTP_ASSERT_NOW(a_unknown_zero, o_out_valid && !o_time_known, o_unix_seconds == 32'd0,
        "unknown time reported with nonzero seconds")
    `SNTP_ASSERT_NOW(a_acc_diff_zero, r1_v && r1_acc, r1_diff == 32'd0,
        "accepted reply did not capture the poll time")
    `SNTP_ASSERT_NOW(a_full_backpressure,
        r0_v && r1_v && r2_v && r3_v && r_out_valid && i_out_stall, o_in_stall,
        "full pipeline took a poll word under output stall")

endmodule
